// File: rtl/core/fixed_block_pool_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top_macros
// assertion helpers used by the block pool allocator datapath
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, off while reset is held
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa: same-cycle check failed");

// next-cycle implication, off while reset is held
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa: next-cycle check failed");

`endif

// File: rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// types, codes and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // sizes
    localparam int unsigned MAX_BLOCKS_DEF = 256;
    localparam int unsigned ADDR_BITS      = 32;
    localparam int unsigned BSIZE_W        = 16;
    localparam int unsigned COUNT_W        = 9;
    localparam int unsigned WORD_BITS      = 8;
    localparam int unsigned BIT_W          = 3;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 32;

    // register values after reset
    localparam logic [ADDR_BITS-1:0] BASE_RST   = 32'd4096;
    localparam logic [BSIZE_W-1:0]   BSIZE_RST  = 16'd32;
    localparam logic [COUNT_W-1:0]   BTOTAL_RST = 9'd256;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_BLOCK_SIZE   = 2'd1,
        CFG_BLOCK_TOTAL  = 2'd2
    } t_cfg_reg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EMPTY        = 2'd1,
        ST_INVALID      = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    // how the result of a request is formed
    typedef enum logic [1:0] {
        KIND_EMPTY   = 2'd0,
        KIND_INVALID = 2'd1,
        KIND_ALLOC   = 2'd2,
        KIND_FREE    = 2'd3
    } t_kind;

    typedef struct packed {
        logic                 op;
        logic [ADDR_BITS-1:0] release_address;
    } t_in_beat;

    typedef struct packed {
        t_status              status;
        logic [ADDR_BITS-1:0] granted_address;
        logic [COUNT_W-1:0]   blocks_left;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic  sweep_wr;
        logic  sweep_done;
        logic  addr_clr;
        logic  addr_inc;
        logic  addr_load_quot;
        logic  mem_rd;
        logic  pick_bit;
        logic  div_start;
        logic  commit;
        t_kind kind;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic addr_zero;
        logic usable_zero;
        logic count_zero;
        logic word_nz;
        logic div_done;
        logic rem_zero;
        logic quot_ok;
        logic sweep_last;
        logic out_free;
        logic cfg_reinit;
    } t_dp_stat;

endpackage

// File: rtl/core/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fbpa_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [fbpa_pkg::ADDR_BITS-1:0]   i_dividend,
    input  logic [fbpa_pkg::BSIZE_W-1:0]     i_divisor,
    output logic                             o_done,
    output logic [fbpa_pkg::ADDR_BITS-1:0]   o_quot,
    output logic [fbpa_pkg::BSIZE_W-1:0]     o_rem
);

    localparam int unsigned CNT_W = $clog2(fbpa_pkg::ADDR_BITS);

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic [fbpa_pkg::ADDR_BITS-1:0]  r_q;
    logic [fbpa_pkg::BSIZE_W-1:0]    r_rem;

    logic [fbpa_pkg::BSIZE_W:0]      rem_sh;
    logic [fbpa_pkg::BSIZE_W:0]      dvs_ext;
    logic [fbpa_pkg::BSIZE_W:0]      rem_diff;
    logic                            fits;

    // one shift and trial subtract
    always_comb begin
        rem_sh   = {r_rem, r_q[fbpa_pkg::ADDR_BITS-1]};
        dvs_ext  = {1'b0, i_divisor};
        rem_diff = rem_sh - dvs_ext;
        fits     = (rem_sh >= dvs_ext);
    end

    // control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(fbpa_pkg::ADDR_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[fbpa_pkg::ADDR_BITS-2:0], fits};
            r_rem <= fits ? rem_diff[fbpa_pkg::BSIZE_W-1:0] : rem_sh[fbpa_pkg::BSIZE_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// File: rtl/core/fbpa_datapath.sv
// ----------------------------------------------------------------------------
// fbpa_datapath
// registers, free bitmap memory, divider, address math and result register
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_top_macros.svh"

module fbpa_datapath #(
    parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_fire,
    input  fbpa_pkg::t_in_beat                i_in,
    input  logic                              i_cfg_fire,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output fbpa_pkg::t_out_beat               o_out,
    input  fbpa_pkg::t_dp_cmd                 i_cmd,
    output fbpa_pkg::t_dp_stat                o_stat
);

    localparam int unsigned NWORDS = (MAX_BLOCKS + fbpa_pkg::WORD_BITS - 1) / fbpa_pkg::WORD_BITS;
    localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int unsigned IDX_W  = AW + fbpa_pkg::BIT_W;
    localparam int unsigned PROD_W = fbpa_pkg::BSIZE_W + IDX_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

    // configuration
    logic [fbpa_pkg::ADDR_BITS-1:0]  r_base_address;
    logic [fbpa_pkg::BSIZE_W-1:0]    r_block_size;
    logic [fbpa_pkg::COUNT_W-1:0]    r_block_total;
    logic [fbpa_pkg::COUNT_W-1:0]    usable;
    logic                            cfg_hit;

    // request and pool state
    fbpa_pkg::t_in_beat              r_in;
    logic [fbpa_pkg::COUNT_W-1:0]    r_free_total;
    logic [AW-1:0]                   r_waddr;
    logic [fbpa_pkg::BIT_W-1:0]      r_bit;
    logic [fbpa_pkg::BIT_W-1:0]      low_bit;
    logic [PROD_W-1:0]               r_prod;

    // free bitmap memory
    logic [fbpa_pkg::WORD_BITS-1:0]  mem [NWORDS];
    logic [fbpa_pkg::WORD_BITS-1:0]  r_rd_word;
    logic [fbpa_pkg::WORD_BITS-1:0]  bit_mask;
    logic                            mem_we;
    logic [fbpa_pkg::WORD_BITS-1:0]  mem_wdata;

    // divider
    logic [fbpa_pkg::ADDR_BITS-1:0]  offset;
    logic                            div_done;
    logic [fbpa_pkg::ADDR_BITS-1:0]  div_quot;
    logic [fbpa_pkg::BSIZE_W-1:0]    div_rem;

    // result
    fbpa_pkg::t_status               res_status;
    logic [fbpa_pkg::ADDR_BITS-1:0]  res_grant;
    logic [fbpa_pkg::COUNT_W-1:0]    res_count;
    logic                            out_free;
    logic                            r_out_valid;
    fbpa_pkg::t_out_beat             r_out;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address <= fbpa_pkg::BASE_RST;
            r_block_size   <= fbpa_pkg::BSIZE_RST;
            r_block_total  <= fbpa_pkg::BTOTAL_RST;
        end else if (i_cfg_fire) begin
            case (i_cfg_index)
                fbpa_pkg::CFG_BASE_ADDRESS: begin
                    r_base_address <= i_cfg_data[fbpa_pkg::ADDR_BITS-1:0];
                end
                fbpa_pkg::CFG_BLOCK_SIZE: begin
                    r_block_size <= i_cfg_data[fbpa_pkg::BSIZE_W-1:0];
                end
                fbpa_pkg::CFG_BLOCK_TOTAL: begin
                    r_block_total <= i_cfg_data[fbpa_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg_hit = (i_cfg_index == fbpa_pkg::CFG_BASE_ADDRESS) ||
                     (i_cfg_index == fbpa_pkg::CFG_BLOCK_SIZE) ||
                     (i_cfg_index == fbpa_pkg::CFG_BLOCK_TOTAL);

    // usable block count: block_total capped at the pool size, zero for empty blocks
    always_comb begin
        if (r_block_size == '0) begin
            usable = '0;
        end else if (32'(r_block_total) > 32'(MAX_BLOCKS)) begin
            usable = fbpa_pkg::COUNT_W'(MAX_BLOCKS);
        end else begin
            usable = r_block_total;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_in <= i_in;
        end
    end

    // offset to block index
    assign offset = r_in.release_address - r_base_address;

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (offset),
        .i_divisor  (r_block_size),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // lowest free bit of the word just read
    always_comb begin
        low_bit = '0;
        for (int i = fbpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (r_rd_word[i]) begin
                low_bit = fbpa_pkg::BIT_W'(i);
            end
        end
    end

    // word address and bit position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waddr <= '0;
        end else if (i_cmd.addr_clr) begin
            r_waddr <= '0;
        end else if (i_cmd.addr_inc) begin
            r_waddr <= r_waddr + AW'(1);
        end else if (i_cmd.addr_load_quot) begin
            r_waddr <= div_quot[fbpa_pkg::BIT_W +: AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_bit) begin
            r_bit <= low_bit;
        end else if (i_cmd.addr_load_quot) begin
            r_bit <= div_quot[fbpa_pkg::BIT_W-1:0];
        end
    end

    // block offset of the granted block, registered before the add
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_block_size) * PROD_W'({r_waddr, r_bit});
    end

    assign bit_mask = fbpa_pkg::WORD_BITS'(1) << r_bit;

    // result of the request and bitmap update
    always_comb begin
        res_status = fbpa_pkg::ST_OK;
        res_grant  = '0;
        res_count  = r_free_total;
        mem_we     = 1'b0;
        mem_wdata  = '1;
        if (i_cmd.sweep_wr) begin
            mem_we = 1'b1;
        end else begin
            case (i_cmd.kind)
                fbpa_pkg::KIND_EMPTY: begin
                    res_status = fbpa_pkg::ST_EMPTY;
                end
                fbpa_pkg::KIND_INVALID: begin
                    res_status = fbpa_pkg::ST_INVALID;
                end
                fbpa_pkg::KIND_ALLOC: begin
                    res_grant = r_base_address + fbpa_pkg::ADDR_BITS'(r_prod);
                    res_count = r_free_total - fbpa_pkg::COUNT_W'(1);
                    mem_we    = i_cmd.commit;
                    mem_wdata = r_rd_word & ~bit_mask;
                end
                fbpa_pkg::KIND_FREE: begin
                    if (r_rd_word[r_bit]) begin
                        res_status = fbpa_pkg::ST_ALREADY_FREE;
                    end else begin
                        res_count = r_free_total + fbpa_pkg::COUNT_W'(1);
                        mem_we    = i_cmd.commit;
                        mem_wdata = r_rd_word | bit_mask;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // bitmap memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_waddr] <= mem_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rd_word <= mem[r_waddr];
        end
    end

    // free block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_total <= '0;
        end else if (i_cmd.sweep_done) begin
            r_free_total <= usable;
        end else if (i_cmd.commit) begin
            r_free_total <= res_count;
        end
    end

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.status          <= res_status;
            r_out.granted_address <= res_grant;
            r_out.blocks_left     <= res_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // status to the controller
    always_comb begin
        o_stat.op          = r_in.op;
        o_stat.addr_zero   = (r_in.release_address == '0);
        o_stat.usable_zero = (usable == '0);
        o_stat.count_zero  = (r_free_total == '0);
        o_stat.word_nz     = |r_rd_word;
        o_stat.div_done    = div_done;
        o_stat.rem_zero    = (div_rem == '0);
        o_stat.quot_ok     = (div_quot < fbpa_pkg::ADDR_BITS'(usable));
        o_stat.sweep_last  = (r_waddr == LAST_WORD);
        o_stat.out_free    = out_free;
        o_stat.cfg_reinit  = i_cfg_fire && cfg_hit;
    end

    // checks
    `FBPA_ASSERT_NOW(a_commit_room, i_clk, i_rst_n, i_cmd.commit, out_free)
    `FBPA_ASSERT_NOW(a_alloc_picks_free, i_clk, i_rst_n, i_cmd.commit && (i_cmd.kind == fbpa_pkg::KIND_ALLOC), (r_free_total != '0) && r_rd_word[r_bit])
    `FBPA_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, i_cmd.commit, r_out_valid)
    `FBPA_ASSERT_NOW(a_sweep_alone, i_clk, i_rst_n, i_cmd.sweep_wr, !i_cmd.commit && !i_cmd.mem_rd)

endmodule

// File: rtl/core/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// sequencer for the clearing pass, allocate scan and free check
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_cfg_valid,
    output logic               o_in_stall,
    output logic               o_cfg_ready,
    input  fbpa_pkg::t_dp_stat i_stat,
    output fbpa_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_DECODE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_GRANT_MUL,
        S_FREE_WAIT,
        S_FREE_CHK,
        S_FREE_RD,
        S_RESULT
    } t_state;

    t_state          r_state;
    t_state          n_state;
    fbpa_pkg::t_kind r_kind;
    fbpa_pkg::t_kind n_kind;
    logic            in_ready;
    logic            in_fire;

    // items are taken only when idle and no config beat is waiting
    assign in_ready    = (r_state == S_IDLE) && !i_cfg_valid;
    assign in_fire     = i_in_valid && in_ready;
    assign o_in_stall  = !in_ready;
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_SWEEP);

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_stat.cfg_reinit) begin
                    o_cmd.addr_clr = 1'b1;
                    n_state        = S_SWEEP;
                end else if (in_fire) begin
                    n_state = S_DECODE;
                end
            end
            S_SWEEP: begin
                if (i_stat.cfg_reinit) begin
                    o_cmd.addr_clr = 1'b1;
                end else begin
                    o_cmd.sweep_wr = 1'b1;
                    o_cmd.addr_inc = 1'b1;
                    if (i_stat.sweep_last) begin
                        o_cmd.sweep_done = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
            end
            S_DECODE: begin
                if (i_stat.op == fbpa_pkg::OP_ALLOC) begin
                    if (i_stat.count_zero) begin
                        n_kind  = fbpa_pkg::KIND_EMPTY;
                        n_state = S_RESULT;
                    end else begin
                        o_cmd.addr_clr = 1'b1;
                        n_state        = S_ALLOC_RD;
                    end
                end else begin
                    if (i_stat.addr_zero || i_stat.usable_zero) begin
                        n_kind  = fbpa_pkg::KIND_INVALID;
                        n_state = S_RESULT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_FREE_WAIT;
                    end
                end
            end
            S_ALLOC_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_ALLOC_CHK;
            end
            S_ALLOC_CHK: begin
                if (i_stat.word_nz) begin
                    o_cmd.pick_bit = 1'b1;
                    n_state        = S_GRANT_MUL;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                    n_state        = S_ALLOC_RD;
                end
            end
            S_GRANT_MUL: begin
                n_kind  = fbpa_pkg::KIND_ALLOC;
                n_state = S_RESULT;
            end
            S_FREE_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (!i_stat.rem_zero || !i_stat.quot_ok) begin
                    n_kind  = fbpa_pkg::KIND_INVALID;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.addr_load_quot = 1'b1;
                    n_state              = S_FREE_RD;
                end
            end
            S_FREE_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_kind       = fbpa_pkg::KIND_FREE;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_kind  <= fbpa_pkg::KIND_EMPTY;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

// File: rtl/core/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// fixed-size block pool allocator with free bitmap and free block count
// ----------------------------------------------------------------------------
// One request at a time. An allocate scans the free bitmap one 8-block
// word at a time from block 0 up to the first free block, reading and then
// checking each word of the single-port bitmap memory, and registers the
// block offset before the granted address is formed. A free that passes
// the null and empty-pool checks waits for the bit-serial divider that
// turns the address offset into a block index (32 steps); null addresses
// and an empty pool answer without the divider. After reset and after
// every write to a known register the bitmap is refilled by a clearing
// pass during which requests are stalled; config beats are still taken
// and restart the pass. A finished result waits in an output register
// while the next request is accepted.
module fixed_block_pool_allocator_top #(
    parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  fbpa_pkg::t_in_beat                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output fbpa_pkg::t_out_beat               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    fbpa_pkg::t_dp_cmd  dp_cmd;
    fbpa_pkg::t_dp_stat dp_stat;
    logic               in_fire;
    logic               cfg_fire;

    // handshakes
    assign in_fire  = i_in_valid && !o_in_stall;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_in        (i_in),
        .i_cfg_fire  (cfg_fire),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

// File: bench/fixed_block_pool_allocator_top_test.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top_test
// self-checking bench for the fixed-size block pool allocator
// ----------------------------------------------------------------------------
// A request-level model of the pool (free bitmap, free count, registers) runs
// beside the block and predicts every result beat when its request beat is
// taken. Directed tests cover the reset pool, double and null frees,
// misaligned and out-of-pool addresses, an unmapped register index, a tiny
// pool run to empty, address wrap at the top of the space, and zero sizes.
// Random phases then reprogram the pool and mix alloc/free traffic, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POOL_SLOTS   = fbpa_pkg::MAX_BLOCKS_DEF;
    localparam logic [fbpa_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned PHASE_ITEMS  = 50;

    logic                             i_clk;
    logic                             i_rst_n      = 1'b0;
    logic                             i_in_valid   = 1'b0;
    logic                             o_in_stall;
    fbpa_pkg::t_in_beat               i_in         = '0;
    logic                             o_out_valid;
    logic                             i_out_stall  = 1'b0;
    fbpa_pkg::t_out_beat              o_out;
    logic                             i_cfg_valid  = 1'b0;
    logic                             o_cfg_ready;
    logic [fbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index  = '0;
    logic [fbpa_pkg::CFG_DATA_W-1:0]  i_cfg_data   = '0;

    // pool model state
    logic [fbpa_pkg::ADDR_BITS-1:0]   pool_base;
    logic [fbpa_pkg::BSIZE_W-1:0]     pool_bsize;
    logic [fbpa_pkg::COUNT_W-1:0]     pool_btotal;
    logic [POOL_SLOTS-1:0]            free_bits;
    logic [fbpa_pkg::COUNT_W-1:0]     model_free;

    fbpa_pkg::t_out_beat pending_outcomes[$];
    fbpa_pkg::t_out_beat want_beat;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;
    bit          idling_on   = 1'b1;

    fixed_block_pool_allocator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // blocks the pool manages: total saturated, none with zero size
    function automatic int unsigned usable_count();
        if (pool_bsize == 0) return 0;
        if (pool_btotal > POOL_SLOTS) return POOL_SLOTS;
        return pool_btotal;
    endfunction

    function automatic void reinit_pool();
        free_bits  = '1;
        model_free = fbpa_pkg::COUNT_W'(usable_count());
    endfunction

    // register write as seen by the pool; unmapped index leaves pool alone
    function automatic void apply_register(logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                                           logic [fbpa_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            fbpa_pkg::CFG_BASE_ADDRESS: pool_base   = data;
            fbpa_pkg::CFG_BLOCK_SIZE:   pool_bsize  = data[fbpa_pkg::BSIZE_W-1:0];
            fbpa_pkg::CFG_BLOCK_TOTAL:  pool_btotal = data[fbpa_pkg::COUNT_W-1:0];
            default:                    return;
        endcase
        reinit_pool();
    endfunction

    // outcome of one request, updating the bitmap and free count
    function automatic fbpa_pkg::t_out_beat allocator_outcome(fbpa_pkg::t_in_beat req);
        fbpa_pkg::t_out_beat            res;
        int unsigned                    n;
        int unsigned                    slot;
        bit                             hit;
        logic [fbpa_pkg::ADDR_BITS-1:0] offset;
        logic [fbpa_pkg::ADDR_BITS-1:0] idx;
        n   = usable_count();
        hit = 1'b0;
        res.status          = fbpa_pkg::ST_OK;
        res.granted_address = '0;
        if (req.op == fbpa_pkg::OP_ALLOC) begin
            // lowest free block wins
            if (model_free != 0) begin
                for (slot = 0; slot < n; slot++) begin
                    if (free_bits[slot]) begin
                        hit = 1'b1;
                        break;
                    end
                end
            end
            if (hit) begin
                free_bits[slot]     = 1'b0;
                model_free          = model_free - 1'b1;
                res.granted_address = pool_base + pool_bsize * slot;
            end else begin
                res.status = fbpa_pkg::ST_EMPTY;
            end
        end else begin
            // map the address back to a block index, with wrap
            offset = req.release_address - pool_base;
            if (req.release_address == 0 || n == 0) begin
                res.status = fbpa_pkg::ST_INVALID;
            end else if ((offset % pool_bsize) != 0) begin
                res.status = fbpa_pkg::ST_INVALID;
            end else begin
                idx = offset / pool_bsize;
                if (idx >= n) begin
                    res.status = fbpa_pkg::ST_INVALID;
                end else if (free_bits[idx]) begin
                    res.status = fbpa_pkg::ST_ALREADY_FREE;
                end else begin
                    free_bits[idx] = 1'b1;
                    model_free     = model_free + 1'b1;
                end
            end
        end
        res.blocks_left = model_free;
        return res;
    endfunction

    // random request, mostly frees of blocks in use and allocs
    function automatic fbpa_pkg::t_in_beat random_request(int unsigned alloc_weight);
        fbpa_pkg::t_in_beat req;
        int unsigned        n;
        int unsigned        pick;
        int unsigned        slot;
        int unsigned        busy[$];
        n = usable_count();
        req.op              = fbpa_pkg::OP_ALLOC;
        req.release_address = $urandom();
        if ($urandom_range(0, 99) < alloc_weight) return req;
        req.op = fbpa_pkg::OP_FREE;
        for (slot = 0; slot < n; slot++) begin
            if (!free_bits[slot]) busy.push_back(slot);
        end
        slot = (n == 0) ? 0 : $urandom_range(0, n - 1);
        pick = $urandom_range(0, 99);
        if (pick < 70 && busy.size() != 0) begin
            slot = busy[$urandom_range(0, busy.size() - 1)];
            req.release_address = pool_base + pool_bsize * slot;
        end else if (pick < 80) begin
            // any block of the pool, often a double free
            req.release_address = pool_base + pool_bsize * slot;
        end else if (pick < 85 && pool_bsize > 1) begin
            req.release_address = pool_base + pool_bsize * slot
                                + $urandom_range(1, pool_bsize - 1);
        end else if (pick < 88) begin
            req.release_address = '0;
        end else if (pick < 92) begin
            req.release_address = pool_base + pool_bsize * n;
        end else if (pick < 95) begin
            req.release_address = pool_base - pool_bsize;
        end
        return req;
    endfunction

    // one request beat; valid stays high into the next beat unless a gap
    task automatic send_request(input fbpa_pkg::t_in_beat req);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_outcomes.push_back(allocator_outcome(req));
    endtask

    task automatic alloc_block();
        send_request('{op: fbpa_pkg::OP_ALLOC, release_address: $urandom()});
    endtask

    task automatic release_block(input logic [fbpa_pkg::ADDR_BITS-1:0] addr);
        send_request('{op: fbpa_pkg::OP_FREE, release_address: addr});
    endtask

    // drop request valid and wait for every result beat
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // config beat; valid held when another beat follows
    task automatic write_register(input logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [fbpa_pkg::CFG_DATA_W-1:0] data,
                                  input bit more_follow);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        if (!more_follow) i_cfg_valid <= 1'b0;
    endtask

    task automatic program_pool(input logic [fbpa_pkg::CFG_DATA_W-1:0] base,
                                input logic [fbpa_pkg::CFG_DATA_W-1:0] bsize,
                                input logic [fbpa_pkg::CFG_DATA_W-1:0] btotal);
        write_register(fbpa_pkg::CFG_BASE_ADDRESS, base, 1'b1);
        write_register(fbpa_pkg::CFG_BLOCK_SIZE, bsize, 1'b1);
        write_register(fbpa_pkg::CFG_BLOCK_TOTAL, btotal, 1'b0);
    endtask

    // result checker and receiver stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $error("result beat with no request outstanding: %p", o_out);
                error_count++;
            end else begin
                want_beat = pending_outcomes.pop_front();
                if (o_out.status !== want_beat.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want_beat.status, o_out.status);
                    error_count++;
                end
                if (o_out.granted_address !== want_beat.granted_address) begin
                    $error("granted_address mismatch: expected %h, actual %h",
                           want_beat.granted_address, o_out.granted_address);
                    error_count++;
                end
                if (o_out.blocks_left !== want_beat.blocks_left) begin
                    $error("blocks_left mismatch: expected %0d, actual %0d",
                           want_beat.blocks_left, o_out.blocks_left);
                    error_count++;
                end
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left  = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // reset pool: lowest-first grant, double free, bad addresses
    task automatic test_reset_defaults();
        alloc_block();
        alloc_block();
        release_block(32'h0000_1000);
        release_block(32'h0000_1000);
        alloc_block();
        release_block(32'h0000_0000);
        release_block(32'h0000_1001);
        release_block(32'h0000_3000);
        release_block(32'h0000_0FE0);
        release_block(32'hFFFF_FFFF);
    endtask

    // unmapped register index must not re-initialize the pool
    task automatic test_ignored_register();
        wait_idle();
        write_register(CFG_UNMAPPED, $urandom(), 1'b0);
        release_block(32'h0000_1020);
    endtask

    // two one-byte blocks at address 0: run to empty, null free
    task automatic test_tiny_pool();
        wait_idle();
        program_pool(32'h0000_0000, 32'd1, 32'd2);
        alloc_block();
        alloc_block();
        alloc_block();
        release_block(32'h0000_0000);
        release_block(32'h0000_0001);
    endtask

    // top of address space, largest block, saturated block total
    task automatic test_wrapping_pool();
        wait_idle();
        program_pool(32'hFFFF_FFFF, 32'd65535, 32'd511);
        alloc_block();
        alloc_block();
        release_block(32'h0000_FFFE);
        release_block(32'h00FE_FF00);
    endtask

    // zero block size, then zero block total
    task automatic test_degenerate_sizes();
        wait_idle();
        write_register(fbpa_pkg::CFG_BLOCK_SIZE, 32'd0, 1'b0);
        alloc_block();
        release_block(32'hFFFF_FFFF);
        wait_idle();
        program_pool(32'h0000_1000, 32'd32, 32'd0);
        alloc_block();
        release_block(32'h0000_1000);
    endtask

    // one reprogrammed pool with random traffic
    task automatic run_random_phase();
        logic [fbpa_pkg::ADDR_BITS-1:0] base;
        logic [fbpa_pkg::BSIZE_W-1:0]   bsize;
        logic [fbpa_pkg::COUNT_W-1:0]   btotal;
        logic [31:0]                    hi;
        int unsigned                    weight;
        wait_idle();
        base = $urandom();
        case ($urandom_range(0, 9))
            0:       base = '0;
            1:       base = '1;
            2:       base = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0:       bsize = 16'd1;
            1:       bsize = 16'hFFFF;
            2:       bsize = $urandom_range(1, 16'hFFFF);
            default: bsize = $urandom_range(1, 48);
        endcase
        case ($urandom_range(0, 9))
            0:       btotal = 9'd256;
            1:       btotal = $urandom_range(257, 511);
            2:       btotal = $urandom_range(13, 255);
            default: btotal = $urandom_range(1, 12);
        endcase
        // unused upper data bits toggle too
        hi = $urandom();
        program_pool(base, {hi[31:16], bsize}, {hi[22:0], btotal});
        weight = $urandom_range(35, 65);
        repeat (PHASE_ITEMS) send_request(random_request(weight));
    endtask

    // random traffic with gaps and stalls, one phase without
    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            idling_on = (phase != 3);
            run_random_phase();
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_quiet_tail();
        idling_on = 1'b0;
        run_random_phase();
        run_random_phase();
        wait_idle();
    endtask

    // sequence
    initial begin
        pool_base   = fbpa_pkg::BASE_RST;
        pool_bsize  = fbpa_pkg::BSIZE_RST;
        pool_btotal = fbpa_pkg::BTOTAL_RST;
        reinit_pool();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_ignored_register();
        test_tiny_pool();
        test_wrapping_pool();
        test_degenerate_sizes();
        test_random_traffic();
        test_quiet_tail();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_div.sv
rtl/core/fbpa_datapath.sv
rtl/core/fbpa_ctrl.sv
rtl/core/fixed_block_pool_allocator_top.sv
bench/fixed_block_pool_allocator_top_test.sv
